>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the vertex generator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define HVG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hvg check failed");

// clocked check that also holds across reset
`define HVG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hvg reset check failed");

`endif

>>> design/hvg_pkg.sv
// ----------------------------------------------------------------------------
// hvg_pkg
// Types, constants and fixed-point helpers of the heightmap vertex generator.
// ----------------------------------------------------------------------------
package hvg_pkg;

    localparam int DIM_W     = 13;
    localparam int H16_W     = 16;
    localparam int Q16_W     = 17;
    localparam int POS_W     = 28;
    localparam int TEX_NUM_W = 30;
    localparam int TEX_DEN_W = 14;

    localparam logic [Q16_W-1:0] FULL_Q16      = 17'd65536;
    localparam logic [17:0]      BAND_DEN      = 18'd196605;
    localparam logic [33:0]      BAND_HALF     = 34'd98302;
    localparam logic [33:0]      HALF_65535    = 34'd32767;
    localparam logic [17:0]      RECIP3        = 18'd174763;
    localparam logic [16:0]      DEN_65535     = 17'd65535;

    typedef enum logic [1:0] {
        SS_BYTE = 2'd0,
        SS_HALF = 2'd1,
        SS_WORD = 2'd2
    } t_sample_size;

    typedef enum logic [2:0] {
        REG_SAMPLE_SIZE  = 3'd0,
        REG_GRID_WIDTH   = 3'd1,
        REG_GRID_HEIGHT  = 3'd2,
        REG_BLOCK_SCALE  = 3'd3,
        REG_HEIGHT_SCALE = 3'd4,
        REG_MULTITEX     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [H16_W-1:0] h16;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] wm1;
        logic [DIM_W-1:0] hm1;
        logic             last;
    } t_item;

    // floor(m / 65535) by folding the 2^16 remainder back in
    function automatic logic [18:0] div65535(input logic [33:0] m);
        logic [17:0] q0;
        logic [18:0] r;
        logic [18:0] q1;
        logic [16:0] r2;
        q0 = m[33:16];
        r  = {1'b0, q0} + {3'b0, m[15:0]};
        q1 = {1'b0, q0} + {16'b0, r[18:16]};
        r2 = {1'b0, r[15:0]} + {14'b0, r[18:16]};
        return q1 + ((r2 >= DEN_65535) ? 19'd1 : 19'd0);
    endfunction

endpackage

>>> design/hvg_queue.sv
// ----------------------------------------------------------------------------
// hvg_queue
// Two-entry queue carrying classified samples from front to back.
// ----------------------------------------------------------------------------
module hvg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hvg_pkg::t_item  i_item,
    input  logic            i_pop,
    output hvg_pkg::t_item  o_item,
    output logic            o_full,
    output logic            o_empty
);
    import hvg_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_full  = r_count[1];
    assign o_empty = (r_count == 2'd0);

endmodule

>>> design/hvg_front.sv
// ----------------------------------------------------------------------------
// hvg_front
// Accepts samples, normalizes height and tracks column/row position.
// ----------------------------------------------------------------------------
module hvg_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [31:0]                 i_sample,
    input  logic [1:0]                  i_sample_size,
    input  logic [hvg_pkg::DIM_W-1:0]   i_grid_width,
    input  logic [hvg_pkg::DIM_W-1:0]   i_grid_height,
    input  logic                        i_full,
    output logic                        o_push,
    output hvg_pkg::t_item              o_item
);
    import hvg_pkg::*;

    localparam int          CLG   = $clog2(MAX_DIM);
    localparam int          CNT_W = (CLG < DIM_W) ? CLG : DIM_W;
    localparam logic [16:0] MAX17 = 17'(MAX_DIM);

    logic [CNT_W-1:0] r_col_cnt, n_col_cnt;
    logic [CNT_W-1:0] r_row_cnt, n_row_cnt;

    logic [DIM_W-1:0] w, h, wm1, hm1, col_raw, row_raw, col, row;
    logic             end_col, end_row;
    logic [H16_W-1:0] h16;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] g);
        if (g < 13'd2) return 13'd2;
        if ({4'b0, g} > MAX17) return MAX17[DIM_W-1:0];
        return g;
    endfunction

    always_comb begin
        w       = clamp_dim(i_grid_width);
        h       = clamp_dim(i_grid_height);
        wm1     = w - 13'd1;
        hm1     = h - 13'd1;
        col_raw = DIM_W'(r_col_cnt);
        row_raw = DIM_W'(r_row_cnt);
        end_col = (col_raw >= wm1);
        end_row = (row_raw >= hm1);
        col     = end_col ? wm1 : col_raw;
        row     = end_row ? hm1 : row_raw;
        case (t_sample_size'(i_sample_size))
            SS_BYTE: h16 = {i_sample[7:0], i_sample[7:0]};
            SS_HALF: h16 = i_sample[15:0];
            default: h16 = i_sample[31:16];
        endcase
        if (end_col) begin
            n_col_cnt = '0;
            n_row_cnt = end_row ? '0 : CNT_W'(row + 13'd1);
        end else begin
            n_col_cnt = CNT_W'(col + 13'd1);
            n_row_cnt = CNT_W'(row);
        end
    end

    assign o_ready = ~i_full;
    assign o_push  = i_valid & ~i_full;

    always_comb begin
        o_item.h16  = h16;
        o_item.col  = col;
        o_item.row  = row;
        o_item.wm1  = wm1;
        o_item.hm1  = hm1;
        o_item.last = end_col & end_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (o_push) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

endmodule

>>> design/hvg_divider.sv
// ----------------------------------------------------------------------------
// hvg_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hvg_divider #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;

    logic [DEN_W:0]   rem_sh;
    logic             q_bit;

    always_comb begin
        rem_sh = {r_rem, r_num[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

>>> design/hvg_back.sv
// ----------------------------------------------------------------------------
// hvg_back
// Computes vertex position, texture coordinates and band weights.
// ----------------------------------------------------------------------------
module hvg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  hvg_pkg::t_item                i_item,
    output logic                          o_pop,
    input  logic [15:0]                   i_block_scale,
    input  logic [15:0]                   i_height_scale,
    input  logic                          i_multitexture_on,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [hvg_pkg::POS_W-1:0] o_pos_x,
    output logic [15:0]                   o_pos_y,
    output logic signed [hvg_pkg::POS_W-1:0] o_pos_z,
    output logic [hvg_pkg::Q16_W-1:0]     o_tex_s,
    output logic [hvg_pkg::Q16_W-1:0]     o_tex_t,
    output logic [hvg_pkg::Q16_W-1:0]     o_low_band_weight,
    output logic [hvg_pkg::Q16_W-1:0]     o_high_band_weight,
    output logic                          o_last_vertex
);
    import hvg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_item  r_item;
    logic   r_out_valid;
    logic   out_free, load;

    logic [TEX_NUM_W-1:0] s_num, t_num, s_quot, t_quot;
    logic [TEX_DEN_W-1:0] s_den, t_den;
    logic                 s_done, t_done;

    logic signed [31:0] r_px_prod, r_pz_prod;
    logic [31:0]        r_py_prod;
    logic [33:0]        r_lo_m, r_hi_m;
    logic [15:0]        r_py;
    logic [17:0]        r_lo_q1;
    logic [16:0]        r_hi_q;
    logic [35:0]        r_lo_prod;

    logic signed [14:0] dx, dz;
    logic [17:0]        n4, lo;
    logic [15:0]        hi;
    logic [18:0]        py_q, lo_q1, hi_q;

    // sequencer
    assign out_free = ~r_out_valid | i_ready;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_CALC;
            ST_CALC: begin
                if (s_done && t_done) begin
                    if (out_free) begin
                        load    = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load)         r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_item;
    end

    // texture coordinates: round(idx * 65536 / (dim - 1))
    always_comb begin
        s_num = {i_item.col, 17'b0} + TEX_NUM_W'(i_item.wm1);
        t_num = {i_item.row, 17'b0} + TEX_NUM_W'(i_item.hm1);
        s_den = {i_item.wm1, 1'b0};
        t_den = {i_item.hm1, 1'b0};
    end

    hvg_divider #(.NUM_W(TEX_NUM_W), .DEN_W(TEX_DEN_W)) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (o_pop),
        .i_num   (s_num),
        .i_den   (s_den),
        .o_done  (s_done),
        .o_quot  (s_quot)
    );

    hvg_divider #(.NUM_W(TEX_NUM_W), .DEN_W(TEX_DEN_W)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (o_pop),
        .i_num   (t_num),
        .i_den   (t_den),
        .o_done  (t_done),
        .o_quot  (t_quot)
    );

    // position and band pipeline, settles well before the dividers finish
    always_comb begin
        dx    = $signed({1'b0, r_item.col, 1'b0}) - $signed({2'b0, r_item.wm1});
        dz    = $signed({1'b0, r_item.row, 1'b0}) - $signed({2'b0, r_item.hm1});
        n4    = {r_item.h16, 2'b00};
        lo    = (n4 < BAND_DEN) ? n4 : BAND_DEN;
        hi    = (n4 > BAND_DEN) ? 16'(n4 - BAND_DEN) : 16'd0;
        py_q  = div65535({2'b0, r_py_prod} + HALF_65535);
        lo_q1 = div65535(r_lo_m);
        hi_q  = div65535(r_hi_m);
    end

    always_ff @(posedge i_clk) begin
        r_px_prod <= 32'(dx * $signed({1'b0, i_block_scale}));
        r_pz_prod <= 32'(dz * $signed({1'b0, i_block_scale}));
        r_py_prod <= r_item.h16 * i_height_scale;
        r_lo_m    <= {lo, 16'b0} + BAND_HALF;
        r_hi_m    <= {2'b0, hi, 16'b0} + HALF_65535;
        r_py      <= py_q[15:0];
        r_lo_q1   <= lo_q1[17:0];
        r_hi_q    <= hi_q[16:0];
        r_lo_prod <= r_lo_q1 * RECIP3;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_pos_x       <= r_px_prod[POS_W:1];
            o_pos_z       <= r_pz_prod[POS_W:1];
            o_pos_y       <= r_py;
            o_tex_s       <= s_quot[Q16_W-1:0];
            o_tex_t       <= t_quot[Q16_W-1:0];
            o_last_vertex <= r_item.last;
            if (i_multitexture_on) begin
                o_low_band_weight  <= FULL_Q16 - r_lo_prod[35:19];
                o_high_band_weight <= FULL_Q16 - r_hi_q;
            end else begin
                o_low_band_weight  <= FULL_Q16;
                o_high_band_weight <= FULL_Q16;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> design/heightmap_vertex_generator_core.sv
// One grid vertex per heightmap sample, samples in raster order; the block
// keeps its own column and row position. Once the back end picks an item
// up, its vertex is complete when the 30-step restoring dividers that form
// the S and T texture coordinates finish; the rest of the math runs alongside.
// Samples are taken into a two-entry queue while a vertex is being computed
// or waits at the output. Configuration writes do not move the position
// counters.
// ----------------------------------------------------------------------------
// heightmap_vertex_generator_core
// Top level: APB register file, front end, queue and back end.
// ----------------------------------------------------------------------------
module heightmap_vertex_generator_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [31:0]                   i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [hvg_pkg::POS_W-1:0] o_pos_x,
    output logic [15:0]                   o_pos_y,
    output logic signed [hvg_pkg::POS_W-1:0] o_pos_z,
    output logic [hvg_pkg::Q16_W-1:0]     o_tex_s,
    output logic [hvg_pkg::Q16_W-1:0]     o_tex_t,
    output logic [hvg_pkg::Q16_W-1:0]     o_low_band_weight,
    output logic [hvg_pkg::Q16_W-1:0]     o_high_band_weight,
    output logic                          o_last_vertex
);
    import hvg_pkg::*;

    logic [1:0]       r_sample_size;
    logic [DIM_W-1:0] r_grid_width;
    logic [DIM_W-1:0] r_grid_height;
    logic [15:0]      r_block_scale;
    logic [15:0]      r_height_scale;
    logic             r_multitexture_on;

    logic   wr_en;
    logic   push, pop, q_full, q_empty;
    t_item  front_item, q_item;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_size     <= 2'd0;
            r_grid_width      <= 13'd256;
            r_grid_height     <= 13'd256;
            r_block_scale     <= 16'd512;
            r_height_scale    <= 16'd8000;
            r_multitexture_on <= 1'b1;
        end else if (wr_en) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_SAMPLE_SIZE:  r_sample_size     <= pwdata[1:0];
                REG_GRID_WIDTH:   r_grid_width      <= pwdata[DIM_W-1:0];
                REG_GRID_HEIGHT:  r_grid_height     <= pwdata[DIM_W-1:0];
                REG_BLOCK_SCALE:  r_block_scale     <= pwdata[15:0];
                REG_HEIGHT_SCALE: r_height_scale    <= pwdata[15:0];
                REG_MULTITEX:     r_multitexture_on <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_SAMPLE_SIZE:  prdata = {30'b0, r_sample_size};
            REG_GRID_WIDTH:   prdata = {19'b0, r_grid_width};
            REG_GRID_HEIGHT:  prdata = {19'b0, r_grid_height};
            REG_BLOCK_SCALE:  prdata = {16'b0, r_block_scale};
            REG_HEIGHT_SCALE: prdata = {16'b0, r_height_scale};
            REG_MULTITEX:     prdata = {31'b0, r_multitexture_on};
            default:          prdata = 32'd0;
        endcase
    end

    hvg_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_sample_size (r_sample_size),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_full        (q_full),
        .o_push        (push),
        .o_item        (front_item)
    );

    hvg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    hvg_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (q_empty),
        .i_item             (q_item),
        .o_pop              (pop),
        .i_block_scale      (r_block_scale),
        .i_height_scale     (r_height_scale),
        .i_multitexture_on  (r_multitexture_on),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_pos_z            (o_pos_z),
        .o_tex_s            (o_tex_s),
        .o_tex_t            (o_tex_t),
        .o_low_band_weight  (o_low_band_weight),
        .o_high_band_weight (o_high_band_weight),
        .o_last_vertex      (o_last_vertex)
    );

endmodule

>>> design/hvg_checker.sv
// ----------------------------------------------------------------------------
// hvg_checker
// Port-level checks on the vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hvg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [27:0] o_pos_x,
    input  logic [15:0] o_pos_y,
    input  logic [27:0] o_pos_z,
    input  logic [16:0] o_tex_s,
    input  logic [16:0] o_tex_t,
    input  logic [16:0] o_low_band_weight,
    input  logic [16:0] o_high_band_weight,
    input  logic        o_last_vertex
);

    `HVG_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_pos_z) && $stable(o_tex_s) && $stable(o_tex_t) && $stable(o_last_vertex))
    `HVG_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)
    `HVG_ASSERT(a_last_corner, i_clk, i_rst_n, o_valid && o_last_vertex |-> o_tex_s == 17'd65536 && o_tex_t == 17'd65536)
    `HVG_ASSERT(a_band_split, i_clk, i_rst_n, o_valid |-> o_high_band_weight == 17'd65536 || o_low_band_weight == 17'd0)
    `HVG_ASSERT(a_tex_range, i_clk, i_rst_n, o_valid |-> o_tex_s <= 17'd65536 && o_tex_t <= 17'd65536)

endmodule

bind heightmap_vertex_generator_core hvg_checker u_hvg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_pos_x            (o_pos_x),
    .o_pos_y            (o_pos_y),
    .o_pos_z            (o_pos_z),
    .o_tex_s            (o_tex_s),
    .o_tex_t            (o_tex_t),
    .o_low_band_weight  (o_low_band_weight),
    .o_high_band_weight (o_high_band_weight),
    .o_last_vertex      (o_last_vertex)
);
